[hw/rtl/feistel_index_permutation_macros.svh]
// Assertion macros shared by the permutation block.
`ifndef FEISTEL_INDEX_PERMUTATION_MACROS_SVH
`define FEISTEL_INDEX_PERMUTATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FIP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/fip_pkg.sv]
package fip_pkg;

    localparam int W  = 64;
    localparam int HW = 32;

    typedef struct packed {
        logic         start;
        logic [W-1:0] a;
        logic [W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic         done;
        logic [W-1:0] p;
    } t_mul_rsp;

endpackage

[hw/rtl/feistel_index_permutation.sv]
// Keyed permutation of the indices 0 .. item_count-1, forward or inverse.
// Configuration: write i_cfg_data to register i_cfg_idx (key or item_count)
// with i_cfg_we, only while the block is idle; there is no read-back.
// Input: a transaction is taken at a rising edge with start high and busy
// low, carrying i_mode (0 forward, 1 inverse) and i_index.
// Output: o_done is high for exactly one cycle with o_value and o_error.
// An index at or above item_count gives o_error set and o_value zero in the
// cycle after the transaction; busy stays low.
// Otherwise the result comes after n network passes, n being the number of
// passes taken before the value falls below item_count; n averages roughly
// the block's range over item_count, which is at most four once item_count
// is four or more.
// Each round takes two 64-bit products, each formed as three
// 32 by 32 partial products on the single shared multiplier.
// One transaction is in progress at a time; busy is high meanwhile and
// falls together with o_done.
// The receiver cannot stall; o_value and o_error hold until the next transaction is taken.
// Reset sets the key to zero, item_count to one and empties the block.
`include "feistel_index_permutation_macros.svh"

module feistel_index_permutation #(
    parameter int ROUNDS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [fip_pkg::W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_mode,
    input  logic [fip_pkg::W-1:0] i_index,
    output logic                  o_done,
    output logic [fip_pkg::W-1:0] o_value,
    output logic                  o_error
);
    import fip_pkg::*;

    localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int HB = $clog2(HW + 1);
    localparam int SB = $clog2(W);
    localparam logic [W-1:0] C_MIX1 = 64'hbf58476d1ce4e5b9;
    localparam logic [W-1:0] C_MIX2 = 64'h94d049bb133111eb;

    typedef enum logic {
        CFG_KEY   = 1'b0,
        CFG_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_XOR   = 7'b0001000,
        S_MUL1  = 7'b0010000,
        S_MUL2  = 7'b0100000,
        S_JOIN  = 7'b1000000
    } t_state;

    function automatic logic [HW-1:0] f_half_mask(input logic [W-1:0] c);
        logic [W-1:0]  s;
        logic [HW-1:0] m;
        s = c;
        for (int sh = 1; sh < W; sh = sh * 2) begin
            s = s | (s >> sh);
        end
        for (int j = 0; j < HW; j++) begin
            m[j] = s[2*j];
        end
        m[1:0] = 2'b11;
        return m;
    endfunction

    function automatic logic [HB-1:0] f_therm_len(input logic [HW-1:0] t);
        logic [HW:0]   te;
        logic [HB-1:0] h;
        te = {1'b0, t};
        h  = '0;
        for (int j = 0; j < HW; j++) begin
            if (te[j] && !te[j+1]) begin
                h = h | HB'(j + 1);
            end
        end
        return h;
    endfunction

    function automatic logic [SB-1:0] f_shift(input logic [RW-1:0] rnd);
        logic [SB-1:0] s;
        s = '0;
        for (int j = 0; j < ROUNDS; j++) begin
            if (rnd == RW'(j)) begin
                s = SB'((j * W) / ROUNDS);
            end
        end
        return s;
    endfunction

    t_state         r_state;
    t_state         n_state;
    logic [W-1:0]   r_key;
    logic [W-1:0]   r_item_count;
    logic           r_mode;
    logic [W-1:0]   r_v;
    logic [HW-1:0]  r_mask;
    logic [HB-1:0]  r_h;
    logic [HW-1:0]  r_lo;
    logic [HW-1:0]  r_rt;
    logic [W-1:0]   r_k;
    logic [RW-1:0]  r_round;
    logic           r_done;
    logic [W-1:0]   r_value;
    logic           r_error;

    logic           accept;
    logic           out_of_range;
    logic           last_round;
    logic [RW-1:0]  ri;
    logic [W-1:0]   k;
    logic [W-1:0]   x0;
    logic [W-1:0]   x1;
    logic [W-1:0]   y;
    logic [W-1:0]   z;
    logic [HW-1:0]  nr;
    logic [W-1:0]   v_split;
    logic [W-1:0]   v_join;
    logic           join_ok;
    t_mul_req       mreq;
    t_mul_rsp       mrsp;

    fip_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_rsp   (mrsp)
    );

    assign busy         = (r_state != S_IDLE);
    assign accept       = start && !busy;
    assign out_of_range = (i_index >= r_item_count);
    assign last_round   = (r_round == RW'(ROUNDS - 1));

    assign ri = r_mode ? (RW'(ROUNDS - 1) - r_round) : r_round;
    assign k  = r_key >> f_shift(ri);
    assign x0 = {{(W-HW){1'b0}}, r_rt} ^ k;
    assign x1 = x0 ^ (x0 >> 30);
    assign y  = mrsp.p ^ (mrsp.p >> 27);
    assign z  = mrsp.p ^ (mrsp.p >> 31);
    assign nr = (r_lo ^ z[HW-1:0] ^ r_k[HW-1:0]) & r_mask;

    assign v_split = r_v >> r_h;
    assign v_join  = ({{(W-HW){1'b0}}, r_rt} << r_h) | {{(W-HW){1'b0}}, r_lo};
    assign join_ok = (v_join < r_item_count);

    assign mreq.start = (r_state == S_XOR) || ((r_state == S_MUL1) && mrsp.done);
    assign mreq.a     = (r_state == S_XOR) ? x1 : y;
    assign mreq.b     = (r_state == S_XOR) ? C_MIX1 : C_MIX2;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !out_of_range) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: n_state = S_LOAD;
            S_LOAD:  n_state = S_XOR;
            S_XOR:   n_state = S_MUL1;
            S_MUL1: begin
                if (mrsp.done) begin
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                if (mrsp.done) begin
                    n_state = last_round ? S_JOIN : S_XOR;
                end
            end
            S_JOIN: begin
                n_state = join_ok ? S_IDLE : S_LOAD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_key        <= '0;
            r_item_count <= W'(1);
            r_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (accept && out_of_range) || ((r_state == S_JOIN) && join_ok);
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_KEY:   r_key        <= i_cfg_data;
                    CFG_COUNT: r_item_count <= i_cfg_data;
                    default:   r_key        <= r_key;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_v     <= i_index;
            r_value <= '0;
            r_error <= 1'b1;
        end
        unique case (r_state)
            S_SETUP: begin
                r_mask <= f_half_mask(r_item_count);
                r_h    <= f_therm_len(f_half_mask(r_item_count));
            end
            S_LOAD: begin
                r_lo    <= v_split[HW-1:0] & r_mask;
                r_rt    <= r_v[HW-1:0] & r_mask;
                r_round <= '0;
            end
            S_XOR: begin
                r_k <= k;
            end
            S_MUL2: begin
                if (mrsp.done) begin
                    r_lo    <= r_rt;
                    r_rt    <= nr;
                    r_round <= r_round + RW'(1);
                end
            end
            S_JOIN: begin
                r_v     <= v_join;
                r_value <= v_join;
                r_error <= 1'b0;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_done  = r_done;
    assign o_value = r_value;
    assign o_error = r_error;

    `FIP_ASSERT_NEXT(a_range_error, accept && out_of_range, o_done && o_error && !busy,
        "out-of-range index did not give an immediate error")
    `FIP_ASSERT_NOW(a_error_zero, o_done && o_error, o_value == '0,
        "error result carries a non-zero value")
    `FIP_ASSERT_NOW(a_done_idle, o_done, !busy,
        "result strobe while a transaction is still in progress")
    `FIP_ASSERT_NOW(a_mul_owner, mrsp.done, (r_state == S_MUL1) || (r_state == S_MUL2),
        "multiplier finished outside a multiply wait state")

endmodule

[hw/rtl/fip_mul.sv]
module fip_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fip_pkg::t_mul_req i_req,
    output fip_pkg::t_mul_rsp o_rsp
);
    import fip_pkg::*;

    typedef enum logic [4:0] {
        MS_IDLE = 5'b00001,
        MS_LL   = 5'b00010,
        MS_HL   = 5'b00100,
        MS_LH   = 5'b01000,
        MS_SUM  = 5'b10000
    } t_mstep;

    t_mstep         r_step;
    t_mstep         n_step;
    logic           r_done;
    logic [W-1:0]   r_a;
    logic [W-1:0]   r_b;
    logic [W-1:0]   r_prod;
    logic [W-1:0]   r_acc;
    logic [HW-1:0]  op_a;
    logic [HW-1:0]  op_b;

    always_comb begin
        n_step = r_step;
        if (i_req.start) begin
            n_step = MS_LL;
        end else begin
            unique case (r_step)
                MS_IDLE: n_step = MS_IDLE;
                MS_LL:   n_step = MS_HL;
                MS_HL:   n_step = MS_LH;
                MS_LH:   n_step = MS_SUM;
                MS_SUM:  n_step = MS_IDLE;
                default: n_step = MS_IDLE;
            endcase
        end
    end

    assign op_a = (r_step == MS_HL) ? r_a[W-1:HW] : r_a[HW-1:0];
    assign op_b = (r_step == MS_LH) ? r_b[W-1:HW] : r_b[HW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= MS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= (r_step == MS_SUM) && !i_req.start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        r_prod <= op_a * op_b;
        unique case (r_step)
            MS_HL: begin
                r_acc <= r_prod;
            end
            MS_LH, MS_SUM: begin
                r_acc[W-1:HW] <= r_acc[W-1:HW] + r_prod[HW-1:0];
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

endmodule

[dv/feistel_index_permutation_tb.sv]
module feistel_index_permutation_tb;
    import fip_pkg::*;

    localparam int ROUNDS = 8;
    localparam logic REG_KEY = 1'b0;
    localparam logic REG_ITEM_COUNT = 1'b1;
    localparam logic MODE_FORWARD = 1'b0;
    localparam logic MODE_INVERSE = 1'b1;
    localparam logic [W-1:0] ALL_ONES = '1;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int CALM_PHASES = 2;

    typedef struct packed {
        logic [W-1:0] value;
        logic         error;
    } t_image;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_idx = 1'b0;
    logic [W-1:0] i_cfg_data = '0;
    logic         start = 1'b0;
    logic         busy;
    logic         i_mode = 1'b0;
    logic [W-1:0] i_index = '0;
    logic         o_done;
    logic [W-1:0] o_value;
    logic         o_error;

    t_image       pending_images[$];
    t_image       head_image;
    logic [W-1:0] key_q = '0;
    logic [W-1:0] count_q = 64'd1;
    int           mismatches = 0;

    feistel_index_permutation #(
        .ROUNDS(ROUNDS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .start(start),
        .busy(busy),
        .i_mode(i_mode),
        .i_index(i_index),
        .o_done(o_done),
        .o_value(o_value),
        .o_error(o_error)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [W-1:0] splitmix_finalize(logic [W-1:0] x);
        x = x ^ (x >> 30);
        x = x * 64'hbf58476d1ce4e5b9;
        x = x ^ (x >> 27);
        x = x * 64'h94d049bb133111eb;
        x = x ^ (x >> 31);
        return x;
    endfunction

    function automatic logic [W-1:0] feistel_pass(logic [W-1:0] v, int half,
                                                  logic [W-1:0] mask, logic inverse);
        logic [W-1:0] left;
        logic [W-1:0] right;
        logic [W-1:0] subkey;
        logic [W-1:0] mixed;
        int           rnd;
        int           i;
        left = (v >> half) & mask;
        right = v & mask;
        for (i = 0; i < ROUNDS; i++) begin
            rnd = inverse ? ROUNDS - 1 - i : i;
            subkey = key_q >> ((rnd * 64) / ROUNDS);
            mixed = (left ^ splitmix_finalize(right ^ subkey) ^ subkey) & mask;
            left = right;
            right = mixed;
        end
        return (right << half) | left;
    endfunction

    function automatic t_image predict_image(logic mode, logic [W-1:0] idx);
        t_image       img;
        logic [W-1:0] rest;
        logic [W-1:0] mask;
        logic [W-1:0] v;
        int           bits;
        img.value = '0;
        img.error = 1'b1;
        if (idx >= count_q) begin
            return img;
        end
        bits = 0;
        rest = count_q;
        while (rest != 0) begin
            bits++;
            rest = rest >> 1;
        end
        if (bits % 2 != 0) begin
            bits++;
        end
        if (bits < 4) begin
            bits = 4;
        end
        mask = (64'd1 << (bits / 2)) - 64'd1;
        v = idx;
        do begin
            v = feistel_pass(v, bits / 2, mask, mode);
        end while (v >= count_q);
        img.value = v;
        img.error = 1'b0;
        return img;
    endfunction

    function automatic logic [W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        $display("mismatch at %0t: %s got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_images.size() == 0) begin
                report_mismatch("result with no transaction outstanding", o_value, '0);
            end else begin
                head_image = pending_images.pop_front();
                if (o_value !== head_image.value) begin
                    report_mismatch("value", o_value, head_image.value);
                end
                if (o_error !== head_image.error) begin
                    report_mismatch("error flag", W'(o_error), W'(head_image.error));
                end
            end
        end
    end

    // The start line is left high after acceptance so that back-to-back transactions
    // need no second assignment in the same step; callers lower it when pausing.
    task automatic send_index(logic mode, logic [W-1:0] idx);
        start <= 1'b1;
        i_mode <= mode;
        i_index <= idx;
        do begin
            @(posedge i_clk);
        end while (busy);
        pending_images.push_back(predict_image(mode, idx));
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_images.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_KEY) begin
            key_q = data;
        end else begin
            count_q = data;
        end
        @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_index(MODE_FORWARD, 64'd0);
        send_index(MODE_INVERSE, 64'd0);
        send_index(MODE_FORWARD, 64'd1);
        send_index(MODE_INVERSE, ALL_ONES);
        wait_idle();
    endtask

    task automatic test_zero_count();
        write_reg(REG_ITEM_COUNT, 64'd0);
        send_index(MODE_FORWARD, 64'd0);
        send_index(MODE_INVERSE, 64'd0);
        send_index(MODE_FORWARD, ALL_ONES);
        send_index(MODE_INVERSE, 64'd5);
        wait_idle();
    endtask

    task automatic test_full_width();
        write_reg(REG_KEY, ALL_ONES);
        write_reg(REG_ITEM_COUNT, ALL_ONES);
        send_index(MODE_FORWARD, 64'd0);
        send_index(MODE_INVERSE, ALL_ONES - 64'd1);
        send_index(MODE_FORWARD, ALL_ONES);
        send_index(MODE_FORWARD, 64'h8000_0000_0000_0000);
        send_index(MODE_INVERSE, 64'h5555_aaaa_3333_cccc);
        wait_idle();
    endtask

    task automatic test_small_domains();
        logic [W-1:0] counts[5];
        int           i;
        counts = '{64'd2, 64'd3, 64'd5, 64'd17, 64'h1_0000_0000};
        write_reg(REG_KEY, 64'h0123_4567_89ab_cdef);
        for (i = 0; i < 5; i++) begin
            write_reg(REG_ITEM_COUNT, counts[i]);
            send_index(MODE_FORWARD, counts[i] - 64'd1);
            send_index(MODE_INVERSE, 64'd0);
            wait_idle();
        end
    endtask

    task automatic test_random_traffic();
        logic [W-1:0] idx;
        int           phase;
        int           n;
        int           len;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 1) begin
                write_reg(REG_KEY, '0);
            end else if (phase == 2) begin
                write_reg(REG_KEY, ALL_ONES);
            end else begin
                write_reg(REG_KEY, random_word());
            end
            // Counts below 16 are left to the directed part; cycle walking is slow for counts below four.
            len = (phase == 0) ? W : $urandom_range(5, W);
            idx = random_word() >> (W - len);
            idx[len-1] = 1'b1;
            write_reg(REG_ITEM_COUNT, idx);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase < RANDOM_PHASES - CALM_PHASES && $urandom_range(0, 3) == 0) begin
                    pause_sender($urandom_range(1, 14));
                end
                case ($urandom_range(0, 19))
                    0:       idx = random_word();
                    1:       idx = count_q + 64'($urandom_range(0, 3));
                    2:       idx = ALL_ONES - 64'($urandom_range(0, 3));
                    3:       idx = count_q - 64'd1;
                    default: idx = random_word() % count_q;
                endcase
                send_index(1'($urandom_range(0, 1)), idx);
            end
            wait_idle();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_zero_count();
        test_full_width();
        test_small_domains();
        test_random_traffic();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
